// File: hw/rtl/bctc_pkg.sv
// ----------------------------------------------------------------------------
// bctc_pkg: shared types and constants of the block cache tag controller
// Transfer payloads, mode codes, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bctc_pkg;

	// number of slots in the fully associative tag store
	localparam int SLOTS  = 16;
	localparam int SLOT_W = $clog2(SLOTS);

	// field widths
	localparam int BLK_W  = 32;
	localparam int BYTE_W = 13;

	localparam logic [BYTE_W-1:0] BLOCK_SIZE_RST = BYTE_W'(512);

	// request mode codes
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_FLUSH = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	typedef struct packed {
		logic [1:0]        mode;
		logic [BLK_W-1:0]  block_number;
		logic [BYTE_W-1:0] offset;
		logic [BYTE_W-1:0] length;
	} req_item_t;

	typedef struct packed {
		logic             status;
		logic             hit;
		logic [3:0]       slot_index;
		logic             writeback_valid;
		logic [BLK_W-1:0] writeback_block;
		logic             fill_valid;
		logic [BLK_W-1:0] fill_block;
		logic             last;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_FLUSH,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;     // register the request
		logic access;      // do lookup/update, load result
		logic flush_step;  // handle current flush slot, advance
		logic emit_done;   // load the flush done result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] mode;
		logic       out_free;
		logic       cur_dirty;
		logic       cnt_last;
	} sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/block_cache_tag_controller_core.sv
// ----------------------------------------------------------------------------
// block_cache_tag_controller_core: write-back block cache tag engine
// Fully associative tag store with round-robin replacement, dirty tracking,
// bounds checking against a programmable block size and a flush sequencer.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload     | role
//  --------+-----------------------+-------------+----------------------------
//  req     | req_valid / req_stall | req_item_t  | access or flush request
//  rsp     | rsp_valid / rsp_stall | rsp_item_t  | access / write-back / done
//  cfg     | cfg_valid / cfg_ready | cfg_data    | block size in bytes
//
//  Read/write/refused access: capture, then lookup and update through the
//  parallel tag compare, one result each. Flush: the slot counter steps
//  one slot per cycle, holding on a dirty slot while the result register
//  is busy; dirty slots each give one result, then the done result.
//  Reset: tags zero, all clean, victim pointer zero, block size 512.
//  A stalled result holds the sequencer only when it needs the result
//  register; a new request is taken while the last result waits.
`default_nettype none

module block_cache_tag_controller_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire bctc_pkg::req_item_t         req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output bctc_pkg::rsp_item_t              rsp,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [bctc_pkg::BYTE_W-1:0] cfg_data
);
	import bctc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	bctc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bctc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// File: hw/rtl/bctc_ctrl.sv
// ----------------------------------------------------------------------------
// bctc_ctrl: sequencing state machine
// Accepts one request at a time, steps a flush over all slots and waits for
// the result register to drain before each result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module bctc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire bctc_pkg::sts_t sts,
	output bctc_pkg::cmd_t     cmd
);
	import bctc_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				priority if (sts.mode == MODE_FLUSH) begin
					state_d = ST_FLUSH;
				end else if (sts.mode == MODE_NONE) begin
					state_d = ST_IDLE;
				end else begin
					// read or write: wait for the result register
					if (sts.out_free) begin
						cmd.access = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				// a dirty slot needs the result register; a clean one does not
				if (!sts.cur_dirty || sts.out_free) begin
					cmd.flush_step = 1'b1;
					if (sts.cnt_last) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit_done = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/bctc_dpath.sv
// ----------------------------------------------------------------------------
// bctc_dpath: tag store, dirty bits, victim pointer and result register
// Parallel tag compare with lowest-slot priority, round-robin victim choice,
// flush slot counter and the block size register.
// ----------------------------------------------------------------------------
`default_nettype none

module bctc_dpath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire bctc_pkg::req_item_t       req,
	input  wire logic                      rsp_stall,
	output logic                           rsp_valid,
	output bctc_pkg::rsp_item_t            rsp,
	input  wire logic                      cfg_valid,
	input  wire logic [bctc_pkg::BYTE_W-1:0] cfg_data,
	input  wire bctc_pkg::cmd_t            cmd,
	output bctc_pkg::sts_t                 sts
);
	import bctc_pkg::*;

	req_item_t          req_q;
	logic [BYTE_W-1:0]  bsize_q;
	logic [BLK_W-1:0]   tags_q [SLOTS];
	logic [SLOTS-1:0]   dirty_q;
	logic [SLOT_W-1:0]  victim_q;
	logic [SLOT_W-1:0]  cnt_q;
	logic               out_valid_q;
	rsp_item_t          out_q;

	logic [BYTE_W:0]    span;
	logic               oob;
	logic [SLOTS-1:0]   match;
	logic               found;
	logic [SLOT_W-1:0]  hit_idx;
	logic [SLOT_W-1:0]  vnext;
	logic [SLOT_W-1:0]  rd_idx;
	logic [BLK_W-1:0]   rd_tag;
	logic               rd_dirty;
	logic               out_free;
	logic               is_write;
	rsp_item_t          acc_res;
	rsp_item_t          wb_res;
	rsp_item_t          done_res;

	// bounds check
	assign span = {1'b0, req_q.offset} + {1'b0, req_q.length};
	assign oob  = span > {1'b0, bsize_q};

	// tag compare, lowest matching slot wins
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = (tags_q[i] == req_q.block_number);
		end
		hit_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = SLOT_W'(i);
			end
		end
	end
	assign found = |match;

	// round-robin pointer advances before it picks
	assign vnext = (victim_q == SLOT_W'(SLOTS - 1)) ? '0 : victim_q + 1'b1;

	// one shared read port: flush counter or next victim
	assign rd_idx   = (req_q.mode == MODE_FLUSH) ? cnt_q : vnext;
	assign rd_tag   = tags_q[rd_idx];
	assign rd_dirty = dirty_q[rd_idx];

	assign out_free = !out_valid_q || !rsp_stall;
	assign is_write = (req_q.mode == MODE_WRITE);

	// result of a read or write access
	always_comb begin
		acc_res = '0;
		acc_res.last = 1'b1;
		if (oob) begin
			acc_res.status = 1'b1;
		end else if (found) begin
			acc_res.hit        = 1'b1;
			acc_res.slot_index = 4'(hit_idx);
		end else begin
			acc_res.slot_index      = 4'(vnext);
			acc_res.writeback_valid = rd_dirty;
			acc_res.writeback_block = rd_dirty ? rd_tag : '0;
			acc_res.fill_valid      = 1'b1;
			acc_res.fill_block      = req_q.block_number;
		end
	end

	// flush write-back and done results
	always_comb begin
		wb_res                 = '0;
		wb_res.slot_index      = 4'(cnt_q);
		wb_res.writeback_valid = 1'b1;
		wb_res.writeback_block = rd_tag;
		done_res               = '0;
		done_res.last          = 1'b1;
	end

	// request capture and block size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsize_q <= BLOCK_SIZE_RST;
		end else if (cfg_valid) begin
			bsize_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	// tag store, dirty bits, victim pointer, flush counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				tags_q[i] <= '0;
			end
			dirty_q  <= '0;
			victim_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (cmd.capture) begin
				cnt_q <= '0;
			end
			if (cmd.access && !oob) begin
				if (found) begin
					if (is_write) begin
						dirty_q[hit_idx] <= 1'b1;
					end
				end else begin
					victim_q       <= vnext;
					tags_q[vnext]  <= req_q.block_number;
					dirty_q[vnext] <= is_write;
				end
			end
			if (cmd.flush_step) begin
				dirty_q[cnt_q] <= 1'b0;
				cnt_q          <= cnt_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.access || (cmd.flush_step && rd_dirty) || cmd.emit_done) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// commands are exclusive; no command keeps the register
	always_ff @(posedge clk) begin
		if (cmd.access) begin
			out_q <= acc_res;
		end else if (cmd.flush_step && rd_dirty) begin
			out_q <= wb_res;
		end else if (cmd.emit_done) begin
			out_q <= done_res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// status to the controller
	always_comb begin
		sts           = '0;
		sts.mode      = req_q.mode;
		sts.out_free  = out_free;
		sts.cur_dirty = rd_dirty;
		sts.cnt_last  = (cnt_q == SLOT_W'(SLOTS - 1));
	end

endmodule

`default_nettype wire

// File: hw/rtl/bctc_checker.sv
// ----------------------------------------------------------------------------
// bctc_checker: port-level checks of the tag controller
// Watches the request and result transfers and the shape of each result.
// ----------------------------------------------------------------------------
`default_nettype none

module bctc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_stall,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_stall,
	input wire bctc_pkg::rsp_item_t         rsp
);
	import bctc_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// one request at a time: the cycle after a transfer is stalled
	a_req_gap: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken in back-to-back cycles");

	// refused access is a lone, empty result
	a_oob_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> rsp.last && !rsp.hit && !rsp.fill_valid
			&& !rsp.writeback_valid)
		else $error("out-of-bounds result carries commands");

	// a hit orders no device traffic
	a_hit_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> !rsp.fill_valid && !rsp.writeback_valid)
		else $error("hit result orders a fill or write-back");

	// flush write-backs are never the final result
	a_flush_wb: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.writeback_valid && !rsp.fill_valid |-> !rsp.last)
		else $error("flush write-back marked last");

endmodule

bind block_cache_tag_controller_core bctc_checker u_bctc_checker (.*);

`default_nettype wire
